[hw/rtl/q2e_pkg.sv]
package q2e_pkg;

  localparam int QUAT_WIDTH_DEF    = 16;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Fixed internal formats
  localparam int FRAC_IN  = 29;  // component fraction bits
  localparam int FRAC_OP  = 30;  // operand fraction bits
  localparam int OP_W     = 36;  // operand width, covers +/-(2^34) range
  localparam int CX_W     = 40;  // cordic x/y datapath width
  localparam int SQ_W     = 62;  // isqrt radicand width (<= 2^60)
  localparam int SQ_STEPS = 31;  // isqrt result bits

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_word_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
  } euler_word_t;

  // atan(2^-i) in units of 2^32 per turn, rounded to nearest
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;  default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/quaternion_to_euler_angles.sv]
// Channel  Dir  Payload        Handshake
// in       in   quat_word_t    in_valid / in_ready
// out      out  euler_word_t   out_valid / out_ready
//
// The pipe runs through component load, products, sums, pitch radicand, the 31-step
// square-root pipeline for pitch cosine, CORDIC pipelines and output round.
// One word per cycle sustained; the whole pipe advances when the last
// stage is empty or being taken. Stalls freeze every stage; nothing lost.
// rst clears the valid bits only.
module quaternion_to_euler_angles #(
  parameter int QUAT_WIDTH    = q2e_pkg::QUAT_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = q2e_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  q2e_pkg::quat_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output q2e_pkg::euler_word_t out_data
);
  localparam int OW   = q2e_pkg::OP_W;
  localparam int SQS  = q2e_pkg::SQ_STEPS;
  localparam int DEP  = 4 + SQS + 1 + CORDIC_STAGES + 1;

  logic [DEP-1:0] vld;
  logic           en;

  assign en       = !vld[DEP-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[DEP-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEP-2:0], in_valid};
  end

  // stage 1: load components at 29 fraction bits (Q1.29, 31 bits signed)
  function automatic logic signed [30:0] load(input logic signed [15:0] v);
    logic signed [QUAT_WIDTH-1:0] q;
    q = QUAT_WIDTH'(v);
    if (QUAT_WIDTH - 1 <= q2e_pkg::FRAC_IN)
      return 31'(signed'(q)) <<< (q2e_pkg::FRAC_IN - (QUAT_WIDTH - 1));
    return 31'(signed'(q) >>> ((QUAT_WIDTH - 1) - q2e_pkg::FRAC_IN));
  endfunction

  logic signed [30:0] cw, cx, cy, cz;
  always_ff @(posedge clk) begin
    if (en) begin
      cw <= load(in_data.quat_w);
      cx <= load(in_data.quat_x);
      cy <= load(in_data.quat_y);
      cz <= load(in_data.quat_z);
    end
  end

  // stage 2: products, 58 fraction bits (31x31 multipliers)
  logic signed [61:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= cw * cx;  p_yz <= cy * cz;  p_xx <= cx * cx;
      p_yy <= cy * cy;  p_wz <= cw * cz;  p_xy <= cx * cy;
      p_zz <= cz * cz;  p_wy <= cw * cy;  p_zx <= cz * cx;
    end
  end

  // stage 3: sums and floor shift to 30 fraction bits
  localparam logic signed [64:0] ONE = 65'sd1 <<< 58;
  logic signed [64:0] e_sr, e_cr, e_sy, e_cy, e_sp;
  assign e_sr = 65'(p_wx) + 65'(p_yz);
  assign e_cr = ONE - ((65'(p_xx) + 65'(p_yy)) <<< 1);
  assign e_sy = 65'(p_wz) + 65'(p_xy);
  assign e_cy = ONE - ((65'(p_yy) + 65'(p_zz)) <<< 1);
  assign e_sp = 65'(p_wy) - 65'(p_zx);

  logic signed [OW-1:0] sr, cr, sy, cyv, sp;
  always_ff @(posedge clk) begin
    if (en) begin
      sr  <= OW'(e_sr >>> 27);
      cr  <= OW'(e_cr >>> 28);
      sy  <= OW'(e_sy >>> 27);
      cyv <= OW'(e_cy >>> 28);
      sp  <= OW'(e_sp >>> 27);
    end
  end

  // stage 4: pitch clamp decision and radicand 2^60 - sp^2
  // the radicand only matters when |sp| < 2^30, so 31 bits of sp suffice
  localparam logic signed [OW-1:0] LIM = OW'(64'sd1 <<< 30);
  logic signed [30:0] sp_lo;
  logic signed [61:0] sp_sq;
  assign sp_lo = sp[30:0];
  assign sp_sq = sp_lo * sp_lo;
  logic                  s4_pos, s4_neg;
  logic [q2e_pkg::SQ_W-1:0] rad;
  logic signed [OW-1:0]  s4_sp;
  always_ff @(posedge clk) begin
    if (en) begin
      s4_pos <= sp >= LIM;
      s4_neg <= sp <= -LIM;
      rad    <= q2e_pkg::SQ_W'((62'sd1 <<< 60) - sp_sq);
      s4_sp  <= sp;
    end
  end

  // square root pipeline, one result bit per stage
  localparam int RW = q2e_pkg::SQ_W;
  logic [RW-1:0]        sq_rem [SQS+1];
  logic [RW-1:0]        sq_res [SQS+1];
  logic signed [OW-1:0] sq_sp  [SQS+1];
  logic                 sq_pos [SQS+1];
  logic                 sq_neg [SQS+1];
  assign sq_rem[0] = rad;
  assign sq_res[0] = '0;
  assign sq_sp[0]  = s4_sp;
  assign sq_pos[0] = s4_pos;
  assign sq_neg[0] = s4_neg;
  for (genvar i = 0; i < SQS; i++) begin : g_sq
    localparam logic [RW-1:0] BIT = RW'(64'd1) << (2 * (SQS - 1 - i));
    logic [RW:0] trial;
    assign trial = (RW+1)'(sq_res[i]) + (RW+1)'(BIT);
    always_ff @(posedge clk) begin
      if (en) begin
        if ((RW+1)'(sq_rem[i]) >= trial) begin
          sq_rem[i+1] <= sq_rem[i] - RW'(trial);
          sq_res[i+1] <= (sq_res[i] >> 1) + BIT;
        end else begin
          sq_rem[i+1] <= sq_rem[i];
          sq_res[i+1] <= sq_res[i] >> 1;
        end
        sq_sp[i+1]  <= sq_sp[i];
        sq_pos[i+1] <= sq_pos[i];
        sq_neg[i+1] <= sq_neg[i];
      end
    end
  end

  // delay roll/yaw operands to line up with the pitch operands
  logic signed [OW-1:0] dl_sr [SQS+2];
  logic signed [OW-1:0] dl_cr [SQS+2];
  logic signed [OW-1:0] dl_sy [SQS+2];
  logic signed [OW-1:0] dl_cy [SQS+2];
  assign dl_sr[0] = sr;
  assign dl_cr[0] = cr;
  assign dl_sy[0] = sy;
  assign dl_cy[0] = cyv;
  for (genvar i = 0; i < SQS + 1; i++) begin : g_dl
    always_ff @(posedge clk) begin
      if (en) begin
        dl_sr[i+1] <= dl_sr[i];
        dl_cr[i+1] <= dl_cr[i];
        dl_sy[i+1] <= dl_sy[i];
        dl_cy[i+1] <= dl_cy[i];
      end
    end
  end

  logic signed [OW-1:0] cp;
  assign cp = OW'(sq_res[SQS]);

  logic [31:0] a_roll, a_yaw, a_pitch;
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(en), .y_in(dl_sr[SQS+1]), .x_in(dl_cr[SQS+1]), .angle(a_roll));
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(en), .y_in(dl_sy[SQS+1]), .x_in(dl_cy[SQS+1]), .angle(a_yaw));
  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(en), .y_in(sq_sp[SQS]), .x_in(cp), .angle(a_pitch));

  // clamp flags follow the cordic pipe
  logic [CORDIC_STAGES:0] cl_pos, cl_neg;
  always_ff @(posedge clk) begin
    if (en) begin
      cl_pos <= {cl_pos[CORDIC_STAGES-1:0], sq_pos[SQS]};
      cl_neg <= {cl_neg[CORDIC_STAGES-1:0], sq_neg[SQS]};
    end
  end

  function automatic logic [ANGLE_WIDTH-1:0] to_angle(input logic [31:0] z);
    logic [32:0] t;
    if (ANGLE_WIDTH >= 32) return ANGLE_WIDTH'(z);
    t = 33'(z) + (33'd1 << (31 - ANGLE_WIDTH));
    return ANGLE_WIDTH'(t >> (32 - ANGLE_WIDTH));
  endfunction

  localparam logic signed [31:0] LIM32 = 32'sh40000000;
  logic signed [31:0] ps;
  logic [31:0]        ps_sat;
  logic [ANGLE_WIDTH-1:0] quarter, pitch_a;
  assign ps      = signed'(a_pitch);
  assign ps_sat  = (ps > LIM32) ? LIM32 : (ps < -LIM32) ? -LIM32 : ps;
  assign quarter = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
  always_comb begin
    priority if (cl_pos[CORDIC_STAGES]) pitch_a = quarter;
    else if (cl_neg[CORDIC_STAGES])     pitch_a = -quarter;
    else                                pitch_a = to_angle(ps_sat);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.roll_angle    <= 16'(signed'(to_angle(a_roll)));
      out_data.pitch_angle   <= 16'(signed'(pitch_a));
      out_data.yaw_angle     <= 16'(signed'(to_angle(a_yaw)));
      out_data.pitch_clamped <= cl_pos[CORDIC_STAGES] | cl_neg[CORDIC_STAGES];
    end
  end
endmodule

[hw/rtl/q2e_cordic.sv]
// Pipelined vectoring CORDIC, one iteration per stage. Advances when en is high.
module q2e_cordic #(
  parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [q2e_pkg::OP_W-1:0]   y_in,
  input  logic signed [q2e_pkg::OP_W-1:0]   x_in,
  output logic [31:0]                       angle
);
  localparam int W = q2e_pkg::CX_W;

  logic signed [W-1:0] xs [STAGES+1];
  logic signed [W-1:0] ys [STAGES+1];
  logic [31:0]         zs [STAGES+1];
  logic                zero_in;
  logic                zf [STAGES+1];
  logic signed [W-1:0] xe, ye;

  assign xe      = W'(x_in);
  assign ye      = W'(y_in);
  assign zero_in = (x_in == '0) && (y_in == '0);

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in < 0) begin
        xs[0] <= -xe;
        ys[0] <= -ye;
        zs[0] <= 32'h80000000;
      end else begin
        xs[0] <= xe;
        ys[0] <= ye;
        zs[0] <= '0;
      end
      zf[0] <= zero_in;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_it
    localparam logic [4:0] K = 5'(i % 32);
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> K);
          ys[i+1] <= ys[i] - (xs[i] >>> K);
          zs[i+1] <= zs[i] + q2e_pkg::atan_turns(K);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> K);
          ys[i+1] <= ys[i] + (xs[i] >>> K);
          zs[i+1] <= zs[i] - q2e_pkg::atan_turns(K);
        end
        zf[i+1] <= zf[i];
      end
    end
  end

  assign angle = zf[STAGES] ? 32'h0 : zs[STAGES];
endmodule

[hw/rtl/q2e_checker.sv]
module q2e_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input q2e_pkg::euler_word_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.pitch_angle <= 16'sd16384
                  && out_data.pitch_angle >= -16'sd16384)
    else $error("pitch out of range");

  a_clamp_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pitch_clamped |->
      out_data.pitch_angle == 16'sd16384 || out_data.pitch_angle == -16'sd16384)
    else $error("clamped pitch not a quarter turn");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));
